// File: src/rlp_pkg.sv
// package for the run-length palette pixel decoder
// types, codes and sizes shared by the interfaces, the top level and the testbench
`default_nettype none

package rlp_pkg;

  // default sizes
  localparam int unsigned MaxDimDefault     = 4096;
  localparam int unsigned PaletteEntriesDef = 256;

  // fixed field widths
  localparam int unsigned IdxW     = 8;
  localparam int unsigned RgbW     = 24;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned CfgDimW  = 13;
  localparam int unsigned RunW     = 6;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 16;

  // byte values of the encoding
  localparam logic [ByteW-1:0] RunMark     = 8'hC0;
  localparam logic [7:0]       AlphaOpaque = 8'hFF;
  localparam logic [7:0]       AlphaClear  = 8'h00;

  typedef enum logic {
    CMD_PALETTE = 1'b0,
    CMD_PIXEL   = 1'b1
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WIDTH  = 8'd0,
    CFG_HEIGHT = 8'd1,
    CFG_PADDED = 8'd2,
    CFG_TRANSP = 8'd3
  } cfg_reg_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EMIT = 1'b1
  } state_e;

  typedef struct packed {
    logic              cmd;
    logic [IdxW-1:0]   palette_index;
    logic [RgbW-1:0]   palette_rgb;
    logic [ByteW-1:0]  data_byte;
  } in_req_t;

  typedef struct packed {
    logic [7:0] pixel_first;
    logic [7:0] pixel_second;
    logic [7:0] pixel_third;
    logic [7:0] pixel_alpha;
    logic       last_of_input;
    logic       frame_done;
  } px_t;

endpackage

`default_nettype wire

// File: src/rlp_in_if.sv
// input request channel: palette writes and encoded image bytes
// depends on rlp_pkg
`default_nettype none

interface rlp_in_if;
  logic             valid;
  logic             ready;
  rlp_pkg::in_req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: src/rlp_out_if.sv
// output pixel channel
// depends on rlp_pkg
`default_nettype none

interface rlp_out_if;
  logic         valid;
  logic         ready;
  rlp_pkg::px_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: src/rlp_cfg_if.sv
// configuration write channel: register index and write data
// depends on rlp_pkg
`default_nettype none

interface rlp_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [rlp_pkg::CfgIdxW-1:0]   index;
  logic [rlp_pkg::CfgDataW-1:0]  wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

// File: src/rlp_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module rlp_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: src/pcx_rle_palette_pixel_decoder.sv
// top level of the run-length palette pixel decoder
// depends on rlp_pkg, rlp_in_if, rlp_out_if, rlp_cfg_if and rlp_ram
//
//   channel  dir  payload                                          request
//   in_i     in   cmd, palette_index, palette_rgb, data_byte       palette write or image byte
//   px_o     out  pixel_first/second/third, pixel_alpha, last/done one rgba pixel
//   cfg_i    in   index, wdata                                     register write
//
// a palette write or a run header is taken while idle and starts no pixel slot;
// a literal byte or the index byte of a run moves the sequencer to its emit
// state, which then walks the pixel slots of that byte.
// the sequencer walks one pixel slot per cycle off the palette ram read data.
// reset clears the decode counters and resets the config; the palette has no
// clearing pass and reads undefined until written. a stalled pixel output holds
// the sequencer, but input is taken whenever the sequencer is idle.
`default_nettype none

module pcx_rle_palette_pixel_decoder #(
  parameter int unsigned MAX_DIM         = rlp_pkg::MaxDimDefault,
  parameter int unsigned PALETTE_ENTRIES = rlp_pkg::PaletteEntriesDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rlp_in_if.sink    in_i,
  rlp_out_if.source px_o,
  rlp_cfg_if.sink   cfg_i
);

  import rlp_pkg::*;

  localparam int unsigned DimW  = $clog2(MAX_DIM + 1);
  localparam int unsigned PixW  = 2 * DimW;
  localparam int unsigned CmpW  = (DimW > CfgDimW) ? DimW : CfgDimW;
  localparam int unsigned AddrW = $clog2(PALETTE_ENTRIES);

  // configuration registers
  logic [CfgDimW-1:0] width_q, height_q;
  logic               padded_q;
  logic [IdxW-1:0]    transp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CfgDimW'(1);
      height_q <= CfgDimW'(1);
      padded_q <= 1'b0;
      transp_q <= '0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        CFG_WIDTH:  width_q  <= cfg_i.wdata[CfgDimW-1:0];
        CFG_HEIGHT: height_q <= cfg_i.wdata[CfgDimW-1:0];
        CFG_PADDED: padded_q <= cfg_i.wdata[0];
        CFG_TRANSP: transp_q <= cfg_i.wdata[IdxW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_i.ready = 1'b1;

  // clamp dimensions to 1 .. MAX_DIM
  logic [CmpW-1:0] width_ext, height_ext;
  logic [DimW-1:0] width_eff, height_eff;

  assign width_ext  = CmpW'(width_q);
  assign height_ext = CmpW'(height_q);

  always_comb begin
    if (width_ext == '0) begin
      width_eff = DimW'(1);
    end else if (width_ext > CmpW'(MAX_DIM)) begin
      width_eff = DimW'(MAX_DIM);
    end else begin
      width_eff = width_ext[DimW-1:0];
    end
    if (height_ext == '0) begin
      height_eff = DimW'(1);
    end else if (height_ext > CmpW'(MAX_DIM)) begin
      height_eff = DimW'(MAX_DIM);
    end else begin
      height_eff = height_ext[DimW-1:0];
    end
  end

  // frame size, registered after the multiply
  logic [PixW-1:0] total_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= PixW'(1);
    end else begin
      total_q <= PixW'(width_eff) * PixW'(height_eff);
    end
  end

  // sequencer and decode state
  state_e          state_q, state_d;
  logic [RunW-1:0] pending_q, pending_d;
  logic [RunW-1:0] remain_q, remain_d;
  logic [DimW-1:0] col_q, col_d;
  logic [PixW-1:0] pix_q, pix_d;
  logic            skip_q, skip_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            out_valid_q, out_valid_d;
  px_t             out_data_q, out_data_d;

  logic            in_accept;
  logic            pal_we, pal_re;
  logic [RgbW-1:0] pal_rdata;
  logic [DimW-1:0] col_inc;
  logic [PixW-1:0] pix_inc;
  logic            row_end, frame_end, step, emit;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_accept  = in_i.valid && in_i.ready;

  assign pal_we = in_accept && (in_i.data.cmd == CMD_PALETTE);
  assign pal_re = in_accept && (in_i.data.cmd == CMD_PIXEL) &&
                  ((pending_q != '0) || (in_i.data.data_byte <= RunMark));

  // palette store
  rlp_ram #(
    .Width (RgbW),
    .Depth (PALETTE_ENTRIES)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (pal_we),
    .waddr_i (in_i.data.palette_index[AddrW-1:0]),
    .wdata_i (in_i.data.palette_rgb),
    .re_i    (pal_re),
    .raddr_i (in_i.data.data_byte[AddrW-1:0]),
    .rdata_o (pal_rdata)
  );

  // one pixel slot per step; a skipped slot needs no output space
  assign col_inc   = col_q + DimW'(1);
  assign pix_inc   = pix_q + PixW'(1);
  assign row_end   = (col_inc >= width_eff);
  assign frame_end = (pix_inc >= total_q);
  assign step      = (state_q == ST_EMIT) && (skip_q || !out_valid_q || px_o.ready);
  assign emit      = step && !skip_q;

  // next state and outputs
  always_comb begin
    state_d     = state_q;
    pending_d   = pending_q;
    remain_d    = remain_q;
    col_d       = col_q;
    pix_d       = pix_q;
    skip_d      = skip_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q && !px_o.ready;
    out_data_d  = out_data_q;

    case (state_q)
      ST_IDLE: begin
        if (in_accept && (in_i.data.cmd == CMD_PIXEL)) begin
          idx_d = in_i.data.data_byte;
          if (pending_q != '0) begin
            remain_d  = pending_q;
            pending_d = '0;
            state_d   = ST_EMIT;
          end else if (in_i.data.data_byte > RunMark) begin
            pending_d = RunW'(in_i.data.data_byte - RunMark);
          end else begin
            remain_d = RunW'(1);
            state_d  = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (step) begin
          remain_d = remain_q - RunW'(1);
          if (remain_q == RunW'(1)) begin
            state_d = ST_IDLE;
          end
          if (skip_q) begin
            skip_d = 1'b0;
          end else begin
            out_valid_d              = 1'b1;
            out_data_d.pixel_first   = pal_rdata[7:0];
            out_data_d.pixel_second  = pal_rdata[15:8];
            out_data_d.pixel_third   = pal_rdata[23:16];
            out_data_d.pixel_alpha   = (idx_q == transp_q) ? AlphaClear : AlphaOpaque;
            out_data_d.frame_done    = frame_end;
            // last emitted slot, also when the only slot left is a padding skip
            out_data_d.last_of_input = frame_end || (remain_q == RunW'(1)) ||
                                       ((remain_q == RunW'(2)) && row_end && padded_q);
            if (frame_end) begin
              // frame complete: drop the rest of the run and clear
              pix_d     = '0;
              col_d     = '0;
              skip_d    = 1'b0;
              pending_d = '0;
              remain_d  = '0;
              state_d   = ST_IDLE;
            end else if (row_end) begin
              pix_d  = pix_inc;
              col_d  = '0;
              skip_d = padded_q;
            end else begin
              pix_d = pix_inc;
              col_d = col_inc;
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pending_q   <= '0;
      remain_q    <= '0;
      col_q       <= '0;
      pix_q       <= '0;
      skip_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pending_q   <= pending_d;
      remain_q    <= remain_d;
      col_q       <= col_d;
      pix_q       <= pix_d;
      skip_q      <= skip_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    out_data_q <= out_data_d;
  end

  assign px_o.valid = out_valid_q;
  assign px_o.data  = out_data_q;

  // checks
  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (px_o.valid && px_o.data.frame_done) |-> px_o.data.last_of_input)
    else $error("frame_done pixel without last_of_input");

  a_frame_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && frame_end) |=> ((pix_q == '0) && (col_q == '0) && !skip_q &&
                             (state_q == ST_IDLE)))
    else $error("decode state not cleared after frame end");

  a_no_pending_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (pending_q == '0))
    else $error("run header pending while a run expands");

  a_emit_needs_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (px_o.valid && !px_o.ready) |=> ($stable(px_o.data) && px_o.valid))
    else $error("stalled pixel overwritten");

endmodule

`default_nettype wire

// File: dv/tb_top.sv
// testbench for the run-length palette pixel decoder: palette writes, literal
// bytes and runs go in, rgba pixels are checked against an in-bench decoder
// depends on rlp_pkg, rlp_in_if, rlp_out_if, rlp_cfg_if and the decoder top level
`timescale 1ns / 1ps

module tb_top;
  import rlp_pkg::*;

  localparam int unsigned MaxDim   = MaxDimDefault;
  localparam int unsigned NumPhase = 8;
  localparam int unsigned SettleCy = 100;

  logic clk_i = 1'b0;
  logic rst_ni;

  rlp_in_if  in_if ();
  rlp_out_if px_if ();
  rlp_cfg_if cfg_if ();

  pcx_rle_palette_pixel_decoder DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .px_o  (px_if),
    .cfg_i (cfg_if)
  );

  always #4 clk_i = ~clk_i;

  // pending requests and expected pixels
  in_req_t     req_q[$];
  px_t         pixel_q[$];
  int unsigned err_cnt;
  int unsigned req_pushed;

  // handshake counters, counted up only by the sampling block
  int unsigned req_taken;
  int unsigned px_taken;
  int unsigned cfg_taken;

  // decoder copy: palette, run and frame position, registers
  logic [RgbW-1:0]    pal_rgb[256];
  logic [RunW-1:0]    run_pending;
  logic [CfgDimW-1:0] col_pos;
  logic [24:0]        frame_pos;
  logic               skip_slot;
  logic [CfgDimW-1:0] reg_width;
  logic [CfgDimW-1:0] reg_height;
  logic               reg_padded;
  logic [IdxW-1:0]    reg_transp;

  // palette entries the stimulus has written so far
  bit pal_known[256];

  // phase settings: width, height, padding, transparent index
  int unsigned ph_w[NumPhase]   = '{0, 8191, 4096, 1, 5, 7, 2, 16};
  int unsigned ph_h[NumPhase]   = '{0, 8191, 1, 4096, 3, 4, 9, 2};
  int unsigned ph_pad[NumPhase] = '{0, 1, 0, 1, 1, 0, 1, 0};
  int unsigned ph_t[NumPhase]   = '{8'hFF, 8'h80, 8'hC0, 8'h00, 0, 0, 0, 0};

  function automatic int unsigned eff_dim(input logic [CfgDimW-1:0] v);
    if (v == '0) return 1;
    if (v > MaxDim) return MaxDim;
    return v;
  endfunction

  // expand one accepted request into the pixels it produces
  task automatic decode_request(input in_req_t req);
    logic [RunW-1:0] run_len;
    logic [IdxW-1:0] idx;
    int unsigned     w;
    int unsigned     total;
    px_t             px;
    px_t             prev;
    bit              have_prev;
    have_prev = 1'b0;
    if (req.cmd == CMD_PALETTE) begin
      pal_rgb[req.palette_index] = req.palette_rgb;
      return;
    end
    if (run_pending != '0) begin
      run_len     = run_pending;
      run_pending = '0;
    end else if (req.data_byte > RunMark) begin
      run_pending = RunW'(req.data_byte - RunMark);
      return;
    end else begin
      run_len = 1;
    end
    idx   = req.data_byte;
    w     = eff_dim(reg_width);
    total = w * eff_dim(reg_height);
    px.pixel_first   = pal_rgb[idx][7:0];
    px.pixel_second  = pal_rgb[idx][15:8];
    px.pixel_third   = pal_rgb[idx][23:16];
    px.pixel_alpha   = (idx == reg_transp) ? AlphaClear : AlphaOpaque;
    px.last_of_input = 1'b0;
    px.frame_done    = 1'b0;
    for (int j = 0; j < run_len; j++) begin
      if (!skip_slot) begin
        if (have_prev) pixel_q.push_back(prev);
        prev      = px;
        have_prev = 1'b1;
        frame_pos++;
        col_pos++;
        // frame complete: drop the rest of the run and clear position
        if (frame_pos >= total) begin
          prev.frame_done = 1'b1;
          run_pending = '0;
          col_pos     = '0;
          frame_pos   = '0;
          skip_slot   = 1'b0;
          break;
        end
      end else begin
        skip_slot = 1'b0;
      end
      if (col_pos >= w) begin
        if (reg_padded) skip_slot = 1'b1;
        col_pos = '0;
      end
    end
    if (have_prev) begin
      prev.last_of_input = 1'b1;
      pixel_q.push_back(prev);
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  // sample all three channels at the rising edge
  always @(posedge clk_i) begin
    px_t exp_px;
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_reg_e'(cfg_if.index))
          CFG_WIDTH:  reg_width  = cfg_if.wdata[CfgDimW-1:0];
          CFG_HEIGHT: reg_height = cfg_if.wdata[CfgDimW-1:0];
          CFG_PADDED: reg_padded = cfg_if.wdata[0];
          CFG_TRANSP: reg_transp = cfg_if.wdata[IdxW-1:0];
          default: ;
        endcase
        cfg_taken++;
      end
      if (in_if.valid && in_if.ready) begin
        decode_request(in_if.data);
        req_taken++;
      end
      if (px_if.valid && px_if.ready) begin
        px_taken++;
        if (pixel_q.size() == 0) begin
          $display("%0t: unexpected pixel, expected none, actual %h", $time, px_if.data);
          err_cnt++;
        end else begin
          exp_px = pixel_q.pop_front();
          check_field("pixel_first", exp_px.pixel_first, px_if.data.pixel_first);
          check_field("pixel_second", exp_px.pixel_second, px_if.data.pixel_second);
          check_field("pixel_third", exp_px.pixel_third, px_if.data.pixel_third);
          check_field("pixel_alpha", exp_px.pixel_alpha, px_if.data.pixel_alpha);
          check_field("last_of_input", 8'(exp_px.last_of_input),
                      8'(px_if.data.last_of_input));
          check_field("frame_done", 8'(exp_px.frame_done), 8'(px_if.data.frame_done));
        end
      end
    end
  end

  // request driver: random gap before each request, calm stretches now and then
  int unsigned req_issued;
  int unsigned req_gap;
  int unsigned req_calm;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!(in_if.valid && req_taken != req_issued)) begin
        if (req_gap > 0) begin
          in_if.valid <= 1'b0;
          req_gap--;
        end else if (req_q.size() > 0) begin
          in_if.data  <= req_q.pop_front();
          in_if.valid <= 1'b1;
          req_issued++;
          if (req_calm > 0) begin
            req_calm--;
            req_gap = 0;
          end else begin
            req_gap = $urandom_range(0, 18);
            if ($urandom_range(0, 15) == 0) req_calm = $urandom_range(10, 40);
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // pixel sink: random stall after each accepted pixel
  int unsigned px_seen;
  int unsigned px_stall;
  int unsigned px_calm;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (px_taken != px_seen) begin
        px_seen = px_taken;
        if (px_calm > 0) begin
          px_calm--;
          px_stall = 0;
        end else begin
          px_stall = $urandom_range(0, 18);
          if ($urandom_range(0, 15) == 0) px_calm = $urandom_range(10, 40);
        end
      end
      if (px_stall > 0) begin
        px_if.ready <= 1'b0;
        px_stall--;
      end else begin
        px_if.ready <= 1'b1;
      end
    end
  end

  // stimulus helpers
  task automatic push_palette(input logic [IdxW-1:0] idx, input logic [RgbW-1:0] rgb);
    in_req_t r;
    r.cmd           = CMD_PALETTE;
    r.palette_index = idx;
    r.palette_rgb   = rgb;
    r.data_byte     = ByteW'($urandom);
    req_q.push_back(r);
    pal_known[idx] = 1'b1;
    req_pushed++;
  endtask

  task automatic push_byte(input logic [ByteW-1:0] b);
    in_req_t r;
    r.cmd           = CMD_PIXEL;
    r.palette_index = IdxW'($urandom);
    r.palette_rgb   = RgbW'($urandom);
    r.data_byte     = b;
    req_q.push_back(r);
    req_pushed++;
  endtask

  function automatic logic [RgbW-1:0] pick_rgb();
    int unsigned s;
    s = $urandom_range(0, 9);
    if (s == 0) return '0;
    if (s == 1) return '1;
    return RgbW'($urandom);
  endfunction

  // index byte, with its palette entry written first if still unknown
  task automatic push_index(input logic [IdxW-1:0] idx);
    if (!pal_known[idx]) push_palette(idx, pick_rgb());
    push_byte(idx);
  endtask

  task automatic push_run(input int unsigned len, input logic [IdxW-1:0] idx);
    push_byte(RunMark + ByteW'(len));
    push_index(idx);
  endtask

  task automatic gen_random(input int unsigned n, input logic [IdxW-1:0] transp);
    int unsigned start;
    int unsigned sel;
    int unsigned len;
    logic [IdxW-1:0] idx;
    start = req_pushed;
    while (req_pushed - start < n) begin
      sel = $urandom_range(0, 99);
      if (sel < 10) begin
        push_palette(IdxW'($urandom), pick_rgb());
      end else if (sel < 45) begin
        idx = IdxW'($urandom_range(0, RunMark));
        if ($urandom_range(0, 6) == 0 && transp <= RunMark) idx = transp;
        push_index(idx);
      end else begin
        len = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 8) : $urandom_range(1, 63);
        idx = IdxW'($urandom);
        if ($urandom_range(0, 6) == 0) idx = transp;
        push_byte(RunMark + ByteW'(len));
        // palette write inside a run
        if ($urandom_range(0, 9) == 0) push_palette(IdxW'($urandom), pick_rgb());
        push_index(idx);
      end
    end
  endtask

  // wait until every request is taken, every pixel seen, and the block settles
  task automatic drain();
    while (req_q.size() != 0 || req_taken != req_issued || pixel_q.size() != 0)
      @(negedge clk_i);
    repeat (SettleCy) @(negedge clk_i);
  endtask

  task automatic cfg_write(input cfg_reg_e ridx, input logic [CfgDataW-1:0] value);
    int unsigned seen;
    seen = cfg_taken;
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= ridx;
    cfg_if.wdata <= value;
    while (cfg_taken == seen) @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // all four registers, unused upper data bits random
  task automatic set_frame(input int unsigned w, input int unsigned h,
                           input int unsigned pad, input int unsigned transp);
    cfg_write(CFG_WIDTH, {3'($urandom), CfgDimW'(w)});
    cfg_write(CFG_HEIGHT, {3'($urandom), CfgDimW'(h)});
    cfg_write(CFG_PADDED, {15'($urandom), 1'(pad)});
    cfg_write(CFG_TRANSP, {8'($urandom), IdxW'(transp)});
  endtask

  initial begin
    int unsigned transp;
    rst_ni       = 1'b0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    px_if.ready  = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.wdata = '0;
    err_cnt      = 0;
    req_pushed   = 0;
    req_taken    = 0;
    px_taken     = 0;
    cfg_taken    = 0;
    req_issued   = 0;
    req_gap      = 0;
    req_calm     = 0;
    px_seen      = 0;
    px_stall     = 0;
    px_calm      = 0;
    run_pending  = '0;
    col_pos      = '0;
    frame_pos    = '0;
    skip_slot    = 1'b0;
    reg_width    = 1;
    reg_height   = 1;
    reg_padded   = 1'b0;
    reg_transp   = '0;
    foreach (pal_rgb[i]) pal_rgb[i] = '0;
    foreach (pal_known[i]) pal_known[i] = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings, one pixel per frame: every pixel ends the frame
    push_palette(8'h00, 24'h000000);
    push_palette(8'hFF, 24'hFFFFFF);
    push_palette(RunMark, 24'h123456);
    push_byte(8'h00);        // transparent index
    push_byte(RunMark);      // 0xc0 is a literal
    push_run(63, 8'hFF);     // longest run, cut at frame end
    push_byte(8'hC1);        // shortest run with a palette write in between
    push_palette(8'h3C, 24'hA5A5A5);
    push_byte(8'h3C);
    drain();

    // padded rows of three, two rows per frame
    set_frame(3, 2, 1, 8'h05);
    push_palette(8'h05, 24'h5A5A5A);
    push_run(4, 8'h05);      // padding slot eats the fourth pixel
    push_byte(8'h05);
    push_run(2, 8'hFF);      // frame ends here
    push_run(3, 8'h00);      // full row, padding slot pending
    push_run(1, 8'hFF);      // run wholly lost to padding
    push_byte(RunMark);
    drain();

    // random phases over several frame shapes
    for (int p = 0; p < NumPhase; p++) begin
      transp = (p >= 4) ? $urandom_range(0, 255) : ph_t[p];
      set_frame(ph_w[p], ph_h[p], ph_pad[p], transp);
      gen_random(49, IdxW'(transp));
      drain();
    end

    if (err_cnt == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  // run limit
  initial begin
    #32_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
